FILE: hw/rtl/tgc_pkg.sv
// Shared types, gesture codes and register indexes for the tilt gesture classifier.
package tgc_pkg;

  // Gesture and sample class codes.
  typedef logic [3:0] gesture_t;
  localparam gesture_t G_RIGHT     = 4'd0;
  localparam gesture_t G_RETURN    = 4'd1;
  localparam gesture_t G_LEFT      = 4'd2;
  localparam gesture_t G_UP        = 4'd3;
  localparam gesture_t G_DOWN      = 4'd4;
  localparam gesture_t G_FORWARD   = 4'd5;
  localparam gesture_t G_HIBERNATE = 4'd6;
  localparam gesture_t G_SHAKE     = 4'd7;
  localparam gesture_t G_UNKNOWN   = 4'd8;

  // Configuration register indexes.
  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_ORIENTATION = 3'd0;
  localparam reg_index_t REG_X_ORIGIN    = 3'd1;
  localparam reg_index_t REG_Y_ORIGIN    = 3'd2;
  localparam reg_index_t REG_TURN_THR    = 3'd3;
  localparam reg_index_t REG_TILT_THR    = 3'd4;
  localparam reg_index_t REG_SHAKE_THR   = 3'd5;

  // Orientation flag bit positions.
  localparam int ORIENT_NEG_X = 0;
  localparam int ORIENT_NEG_Y = 1;
  localparam int ORIENT_SWAP  = 3;

  // Run counter.
  typedef logic [5:0] run_t;
  localparam run_t HIBERNATE_RUN = 6'd40;
  localparam run_t RUN_MAX       = 6'd63;

  typedef logic signed [15:0] sample_t;
  typedef logic [14:0]        thr_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [3:0] orientation_flags;
    sample_t    x_origin;
    sample_t    y_origin;
    thr_t       turn_threshold;
    thr_t       tilt_threshold;
    thr_t       shake_threshold;
  } cfg_t;

endpackage

FILE: hw/rtl/tgc_if.sv
// Handshake interfaces for the sample, result and configuration channels.
interface tgc_sample_if;
  logic                   valid;
  logic                   ready;
  logic signed [15:0]     raw_ax;
  logic signed [15:0]     raw_ay;
  logic                   consumed;
  modport source (output valid, output raw_ax, output raw_ay, output consumed, input ready);
  modport sink   (input valid, input raw_ax, input raw_ay, input consumed, output ready);
endinterface

interface tgc_result_if;
  logic       valid;
  logic       ready;
  logic       gesture_valid;
  logic [3:0] gesture;
  logic [3:0] sample_class;
  modport source (output valid, output gesture_valid, output gesture, output sample_class,
                  input ready);
  modport sink   (input valid, input gesture_valid, input gesture, input sample_class,
                  output ready);
endinterface

interface tgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/tilt_gesture_classifier_top.sv
// Top level of the tilt gesture classifier.
// A sample goes from the input register to the result register, which drives the result beat.
// Throughput: one sample per cycle while results are taken; a stalled result lets one more
// beat into the input register, after which the sample channel stalls as well.
// Reset (rst, synchronous, active high) restores the register defaults, clears
// the held gesture and the class history, and empties both pipeline registers.
module tilt_gesture_classifier_top (
  input  logic          clk,
  input  logic          rst,
  tgc_sample_if.sink    sample,
  tgc_result_if.source  result,
  tgc_cfg_if.sink       cfg
);
  import tgc_pkg::*;

  cfg_t     regs;
  logic     s1_valid;
  sample_t  s1_ax;
  sample_t  s1_ay;
  logic     s1_consumed;
  gesture_t s1_class;
  logic     out_free;
  logic     load;

  assign load         = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;

  tgc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_ax       <= sample.raw_ax;
      s1_ay       <= sample.raw_ay;
      s1_consumed <= sample.consumed;
    end
  end

  tgc_classify u_classify (
    .raw_ax       (s1_ax),
    .raw_ay       (s1_ay),
    .regs         (regs),
    .sample_class (s1_class)
  );

  tgc_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .consumed     (s1_consumed),
    .sample_class (s1_class),
    .out_free     (out_free),
    .result       (result)
  );

  // A waiting sample stays in the input register until it is loaded.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_ax) && $stable(s1_ay))
    else $error("input register lost a waiting sample");
  // A loaded sample is replaced only by a new beat.
  a_s1_drain: assert property (@(posedge clk) disable iff (rst)
    load && !sample.valid |=> !s1_valid)
    else $error("input register valid without a new beat");
  // The classifier only ever produces codes up to unknown.
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_class <= G_UNKNOWN && s1_class != G_RETURN && s1_class != G_FORWARD &&
    s1_class != G_HIBERNATE)
    else $error("classifier produced a gesture-only code");
endmodule

FILE: hw/rtl/tgc_cfg_regs.sv
// Configuration register file written through the configuration channel.
module tgc_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  tgc_cfg_if.sink      cfg,
  output tgc_pkg::cfg_t regs
);
  import tgc_pkg::*;

  cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign regs      = cfg_q;

  // One register per beat; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.orientation_flags <= 4'd0;
      cfg_q.x_origin          <= 16'sd0;
      cfg_q.y_origin          <= 16'sd0;
      cfg_q.turn_threshold    <= 15'd4000;
      cfg_q.tilt_threshold    <= 15'd5000;
      cfg_q.shake_threshold   <= 15'd1000;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ORIENTATION: cfg_q.orientation_flags <= cfg.data[3:0];
        REG_X_ORIGIN:    cfg_q.x_origin          <= cfg.data;
        REG_Y_ORIGIN:    cfg_q.y_origin          <= cfg.data;
        REG_TURN_THR:    cfg_q.turn_threshold    <= cfg.data[14:0];
        REG_TILT_THR:    cfg_q.tilt_threshold    <= cfg.data[14:0];
        REG_SHAKE_THR:   cfg_q.shake_threshold   <= cfg.data[14:0];
        default: ;
      endcase
    end
  end
endmodule

FILE: hw/rtl/tgc_classify.sv
// Offset and orientation correction followed by threshold classification.
module tgc_classify (
  input  tgc_pkg::sample_t  raw_ax,
  input  tgc_pkg::sample_t  raw_ay,
  input  tgc_pkg::cfg_t     regs,
  output tgc_pkg::gesture_t sample_class
);
  import tgc_pkg::*;

  logic [15:0]        dx;
  logic [15:0]        dy;
  logic [15:0]        nx;
  logic [15:0]        ny;
  logic signed [16:0] vx;
  logic signed [16:0] vy;
  logic signed [16:0] turn;
  logic signed [16:0] tilt;
  logic signed [16:0] shk;

  // Subtract the origin and apply the negations, all with 16-bit wrap.
  always_comb begin
    dx = raw_ax - regs.x_origin;
    dy = raw_ay - regs.y_origin;
    nx = regs.orientation_flags[ORIENT_NEG_X] ? 16'(-dx) : dx;
    ny = regs.orientation_flags[ORIENT_NEG_Y] ? 16'(-dy) : dy;
  end

  // The swap comes after the negations; compares run on 17 bits.
  always_comb begin
    if (regs.orientation_flags[ORIENT_SWAP]) begin
      vx = {ny[15], ny};
      vy = {nx[15], nx};
    end else begin
      vx = {nx[15], nx};
      vy = {ny[15], ny};
    end
    turn = {2'b00, regs.turn_threshold};
    tilt = {2'b00, regs.tilt_threshold};
    shk  = {2'b00, regs.shake_threshold};
  end

  // Y is tested first; X only when Y gives no class.
  always_comb begin
    if (vy > turn) begin
      sample_class = G_LEFT;
    end else if (vy < -turn) begin
      sample_class = G_RIGHT;
    end else if (vy > shk || vy < -shk) begin
      sample_class = G_SHAKE;
    end else if (vx > tilt) begin
      sample_class = G_UP;
    end else if (vx < -tilt) begin
      sample_class = G_DOWN;
    end else if (vx > shk || vx < -shk) begin
      sample_class = G_SHAKE;
    end else begin
      sample_class = G_UNKNOWN;
    end
  end
endmodule

FILE: hw/rtl/tgc_tracker.sv
// Class history, run counter, held gesture and the result register.
module tgc_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              consumed,
  input  tgc_pkg::gesture_t sample_class,
  output logic              out_free,
  tgc_result_if.source      result
);
  import tgc_pkg::*;

  logic     held_valid;
  gesture_t held_gesture;
  gesture_t previous_class;
  gesture_t second_previous_class;
  run_t     run_length;
  logic     out_valid;
  gesture_t out_class;

  logic     held_valid_next;
  gesture_t held_gesture_next;
  run_t     run_length_next;
  logic     live_valid;
  logic     three_equal;
  logic     same_class;

  assign out_free             = !out_valid || result.ready;
  assign result.valid         = out_valid;
  assign result.gesture_valid = held_valid;
  assign result.gesture       = held_gesture;
  assign result.sample_class  = out_class;

  // Next history and held gesture for the sample now being loaded.
  always_comb begin
    live_valid  = held_valid && !consumed;
    same_class  = sample_class == previous_class;
    three_equal = same_class && (previous_class == second_previous_class);
    if (same_class) begin
      run_length_next = (run_length == RUN_MAX) ? RUN_MAX : run_length + 6'd1;
    end else begin
      run_length_next = 6'd1;
    end
    held_valid_next   = live_valid;
    held_gesture_next = held_gesture;
    if (!live_valid) begin
      if (sample_class != G_UNKNOWN) begin
        held_valid_next   = 1'b1;
        held_gesture_next = sample_class;
      end
      if (three_equal && sample_class == G_UP) begin
        held_valid_next   = 1'b1;
        held_gesture_next = G_FORWARD;
      end else if (three_equal && sample_class == G_DOWN) begin
        held_valid_next   = 1'b1;
        held_gesture_next = G_RETURN;
      end
      if (run_length_next >= HIBERNATE_RUN && sample_class != G_SHAKE &&
          sample_class != G_UNKNOWN) begin
        held_valid_next   = 1'b1;
        held_gesture_next = G_HIBERNATE;
      end
    end
  end

  // State and result advance together on each loaded sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid            <= 1'b0;
      held_gesture          <= G_UNKNOWN;
      previous_class        <= G_UNKNOWN;
      second_previous_class <= G_UNKNOWN;
      run_length            <= 6'd0;
      out_valid             <= 1'b0;
    end else begin
      if (load) begin
        held_valid            <= held_valid_next;
        held_gesture          <= held_gesture_next;
        second_previous_class <= previous_class;
        previous_class        <= sample_class;
        run_length            <= run_length_next;
        out_valid             <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_class <= sample_class;
    end
  end

  // A load is only issued when the result register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> out_free)
    else $error("sample loaded while result register is full");
  // Every loaded sample leaves a run of at least one.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    load |=> run_length != 6'd0)
    else $error("run counter zero after a sample");
  // A held gesture is never the unknown code.
  a_held_known: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> held_gesture != G_UNKNOWN)
    else $error("held gesture is unknown");
  // A free slot with a known class always latches a gesture.
  a_latch_known: assert property (@(posedge clk) disable iff (rst)
    load && !live_valid && sample_class != G_UNKNOWN |=> held_valid)
    else $error("known class not latched");
endmodule

FILE: tb/sv/tilt_gesture_classifier_top_test.sv
// Self-checking testbench for the tilt gesture classifier top level.
`timescale 1ns / 1ps

module tilt_gesture_classifier_top_test;
  import tgc_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE       = 4;      // edges waited once every result is back
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 181;
  localparam int CYCLE_LIMIT  = 200000;

  // Register indexes outside the list; writes to them must change nothing.
  localparam reg_index_t REG_SPARE_LO = 3'd6;
  localparam reg_index_t REG_SPARE_HI = 3'd7;

  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_MIN = 16'sh8000;

  typedef enum int {PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_t;

  // One result beat as the consumer sees it.
  typedef struct packed {
    logic     gesture_valid;
    gesture_t gesture;
    gesture_t sample_class;
  } gesture_result_t;

  // A directed row is either a sample beat or a register write (data in ax).
  typedef struct packed {
    logic            is_write;
    reg_index_t      index;
    sample_t         ax;
    sample_t         ay;
    logic            consumed;
    logic            typed;
    gesture_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  tgc_sample_if sample_bus ();
  tgc_result_if result_bus ();
  tgc_cfg_if    cfg_bus ();

  tilt_gesture_classifier_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: its own copy of the registers and of the gesture history.
  cfg_t     model_cfg;
  logic     held_valid;
  gesture_t held_gesture;
  gesture_t prev_class;
  gesture_t prev2_class;
  run_t     run_len;

  gesture_result_t pending_results[$];

  int    n_errors;
  int    n_samples;
  int    n_results;
  int    n_writes;
  int    n_settings;
  int    n_long_press;
  int    n_hibernate;
  int    cycles;
  int    idle_pct;
  int    stall_pct;
  logic  cfg_open;

  // Directed stimulus at the reset settings, then the wrap and swap cases.
  directed_row_t directed_table [24] = '{
    '{1'b0, REG_ORIENTATION, 16'sd0, 16'sd0, 1'b0, 1'b1, '{1'b0, G_UNKNOWN, G_UNKNOWN}},
    '{1'b0, REG_ORIENTATION, 16'sd0, S_MAX, 1'b0, 1'b1, '{1'b1, G_LEFT, G_LEFT}},
    '{1'b0, REG_ORIENTATION, 16'sd0, S_MIN, 1'b0, 1'b1, '{1'b1, G_LEFT, G_RIGHT}},
    '{1'b0, REG_ORIENTATION, 16'sd0, 16'sd4000, 1'b1, 1'b1, '{1'b1, G_SHAKE, G_SHAKE}},
    '{1'b0, REG_ORIENTATION, 16'sd0, 16'sd4001, 1'b1, 1'b1, '{1'b1, G_LEFT, G_LEFT}},
    '{1'b0, REG_ORIENTATION, 16'sd0, -16'sd4001, 1'b1, 1'b1, '{1'b1, G_RIGHT, G_RIGHT}},
    '{1'b0, REG_ORIENTATION, 16'sd5001, 16'sd0, 1'b1, 1'b1, '{1'b1, G_UP, G_UP}},
    '{1'b0, REG_ORIENTATION, 16'sd5001, 16'sd0, 1'b1, 1'b1, '{1'b1, G_UP, G_UP}},
    '{1'b0, REG_ORIENTATION, S_MAX, 16'sd1000, 1'b1, 1'b1, '{1'b1, G_FORWARD, G_UP}},
    '{1'b0, REG_ORIENTATION, -16'sd5001, 16'sd0, 1'b1, 1'b1, '{1'b1, G_DOWN, G_DOWN}},
    '{1'b0, REG_ORIENTATION, S_MIN, -16'sd1000, 1'b1, 1'b1, '{1'b1, G_DOWN, G_DOWN}},
    '{1'b0, REG_ORIENTATION, -16'sd5001, 16'sd0, 1'b1, 1'b1, '{1'b1, G_RETURN, G_DOWN}},
    '{1'b0, REG_ORIENTATION, 16'sd5000, 16'sd0, 1'b1, 1'b1, '{1'b1, G_SHAKE, G_SHAKE}},
    '{1'b0, REG_ORIENTATION, 16'sd1000, -16'sd1000, 1'b1, 1'b1, '{1'b0, G_SHAKE, G_UNKNOWN}},
    '{1'b0, REG_ORIENTATION, -16'sd1001, 16'sd0, 1'b0, 1'b1, '{1'b1, G_SHAKE, G_SHAKE}},
    '{1'b1, REG_SPARE_HI, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_SPARE_LO, -16'sd1, 16'sd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_ORIENTATION, 16'sd0, 16'sd1001, 1'b1, 1'b1, '{1'b1, G_SHAKE, G_SHAKE}},
    '{1'b1, REG_ORIENTATION, 16'sd3, 16'sd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_X_ORIGIN, S_MAX, 16'sd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_ORIENTATION, S_MIN, 16'sd0, 1'b1, 1'b0, '0},
    '{1'b0, REG_ORIENTATION, S_MAX, S_MIN, 1'b1, 1'b0, '0},
    '{1'b1, REG_ORIENTATION, 16'sd12, 16'sd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_ORIENTATION, 16'sd12000, 16'sd0, 1'b1, 1'b0, '0}
  };

  // Threshold classification of one corrected sample.
  function automatic gesture_t class_of(sample_t vx, sample_t vy);
    int xv    = vx;
    int yv    = vy;
    int turn  = int'(model_cfg.turn_threshold);
    int tilt  = int'(model_cfg.tilt_threshold);
    int shake = int'(model_cfg.shake_threshold);
    if (yv > turn) return G_LEFT;
    if (yv < -turn) return G_RIGHT;
    if (yv > shake || yv < -shake) return G_SHAKE;
    if (xv > tilt) return G_UP;
    if (xv < -tilt) return G_DOWN;
    if (xv > shake || xv < -shake) return G_SHAKE;
    return G_UNKNOWN;
  endfunction

  // Advances the gesture history by one sample and returns the result beat.
  function automatic gesture_result_t predict_gesture(sample_t ax, sample_t ay,
                                                      logic consumed);
    sample_t  cx;
    sample_t  cy;
    sample_t  tmp;
    gesture_t cls;
    logic     three_equal;
    if (consumed) held_valid = 1'b0;
    cx = ax - model_cfg.x_origin;
    cy = ay - model_cfg.y_origin;
    if (model_cfg.orientation_flags[ORIENT_NEG_X]) cx = -cx;
    if (model_cfg.orientation_flags[ORIENT_NEG_Y]) cy = -cy;
    if (model_cfg.orientation_flags[ORIENT_SWAP]) begin
      tmp = cx;
      cx  = cy;
      cy  = tmp;
    end
    cls = class_of(cx, cy);

    three_equal = (cls == prev_class) && (prev_class == prev2_class);
    if (cls == prev_class) begin
      if (run_len != RUN_MAX) run_len = run_len + 6'd1;
    end else begin
      run_len = 6'd1;
    end
    prev2_class = prev_class;
    prev_class  = cls;

    // Latch only while the consumer holds nothing; promotions override the plain class.
    if (!held_valid) begin
      if (cls != G_UNKNOWN) begin
        held_valid   = 1'b1;
        held_gesture = cls;
      end
      if (three_equal && cls == G_UP) begin
        held_gesture = G_FORWARD;
        n_long_press++;
      end else if (three_equal && cls == G_DOWN) begin
        held_gesture = G_RETURN;
        n_long_press++;
      end
      if (run_len >= HIBERNATE_RUN && cls != G_SHAKE && cls != G_UNKNOWN) begin
        held_gesture = G_HIBERNATE;
        n_hibernate++;
      end
    end
    return '{held_valid, held_gesture, cls};
  endfunction

  // Random value in [lo, hi], landing on lo at least a quarter of the time.
  function automatic int span(int lo, int hi);
    if (hi <= lo || $urandom_range(3) == 0) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int flip(int v);
    return $urandom_range(1) ? v : -v;
  endfunction

  // Picks a corrected sample in the region of the target class, then undoes the
  // origin, negation and swap so that the raw beat lands there.
  function automatic void shape_sample(input gesture_t target, output sample_t ax,
                                       output sample_t ay);
    int      turn  = int'(model_cfg.turn_threshold);
    int      tilt  = int'(model_cfg.tilt_threshold);
    int      shake = int'(model_cfg.shake_threshold);
    int      quiet_y;
    int      quiet_x;
    int      vx;
    int      vy;
    sample_t bx;
    sample_t by;
    quiet_y = (turn < shake) ? turn : shake;
    quiet_x = (tilt < shake) ? tilt : shake;
    vx = int'($urandom_range(65535)) - 32768;
    vy = flip(quiet_y - span(0, quiet_y));
    case (target)
      G_LEFT:  vy = span(turn + 1, 32767);
      G_RIGHT: vy = -span(turn + 1, 32768);
      G_UP:    vx = span(tilt + 1, 32767);
      G_DOWN:  vx = -span(tilt + 1, 32768);
      G_SHAKE: begin
        if (shake < turn && $urandom_range(1)) vy = flip(span(shake + 1, turn));
        else vx = flip(span(shake + 1, tilt));
      end
      default: vx = flip(quiet_x - span(0, quiet_x));
    endcase
    bx = model_cfg.orientation_flags[ORIENT_SWAP] ? sample_t'(vy) : sample_t'(vx);
    by = model_cfg.orientation_flags[ORIENT_SWAP] ? sample_t'(vx) : sample_t'(vy);
    if (model_cfg.orientation_flags[ORIENT_NEG_X]) bx = -bx;
    if (model_cfg.orientation_flags[ORIENT_NEG_Y]) by = -by;
    ax = bx + model_cfg.x_origin;
    ay = by + model_cfg.y_origin;
  endfunction

  function automatic void report(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    n_errors++;
  endfunction

  // Result side: check each accepted beat, then stall at random for the next edge.
  always @(posedge clk) begin
    gesture_result_t want;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0d/%0d/%0d", $time,
                   result_bus.gesture_valid, result_bus.gesture, result_bus.sample_class);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (result_bus.gesture_valid !== want.gesture_valid)
            report("gesture_valid", want.gesture_valid, result_bus.gesture_valid);
          if (result_bus.gesture !== want.gesture)
            report("gesture", want.gesture, result_bus.gesture);
          if (result_bus.sample_class !== want.sample_class)
            report("sample_class", want.sample_class, result_bus.sample_class);
        end
      end
      result_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
      $display("tilt_gesture_classifier_top_test: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes happen only with the sample side quiet and every result back.
  task automatic begin_writes();
    if (!cfg_open) begin
      sample_bus.valid <= 1'b0;
      wait_drained();
      cfg_open = 1'b1;
    end
  endtask

  task automatic end_writes();
    if (cfg_open) begin
      cfg_bus.valid <= 1'b0;
      cfg_open = 1'b0;
    end
  endtask

  task automatic write_register(reg_index_t idx, logic [15:0] value);
    begin_writes();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    n_writes++;
    case (idx)
      REG_ORIENTATION: model_cfg.orientation_flags = value[3:0];
      REG_X_ORIGIN:    model_cfg.x_origin          = value;
      REG_Y_ORIGIN:    model_cfg.y_origin          = value;
      REG_TURN_THR:    model_cfg.turn_threshold    = value[14:0];
      REG_TILT_THR:    model_cfg.tilt_threshold    = value[14:0];
      REG_SHAKE_THR:   model_cfg.shake_threshold   = value[14:0];
      default: ;
    endcase
  endtask

  // Sends one sample beat with random gaps ahead of it and records its result.
  task automatic send_sample(sample_t ax, sample_t ay, logic consumed, logic typed = 1'b0,
                             gesture_result_t want = '0);
    gesture_result_t predicted;
    end_writes();
    while ($urandom_range(99) < idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid    <= 1'b1;
    sample_bus.raw_ax   <= ax;
    sample_bus.raw_ay   <= ay;
    sample_bus.consumed <= consumed;
    do @(posedge clk); while (!sample_bus.ready);
    predicted = predict_gesture(ax, ay, consumed);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    n_samples++;
  endtask

  // One register setting per phase: fixed ones first (reset values, a moderate set, two extremes), then random ones.
  task automatic program_setting(int phase);
    logic [15:0] flags;
    logic [15:0] x_org;
    logic [15:0] y_org;
    logic [15:0] turn;
    logic [15:0] tilt;
    logic [15:0] shake;
    case (phase)
      0: begin
        flags = 16'h0000; x_org = 16'h0000; y_org = 16'h0000;
        turn = 16'd4000; tilt = 16'd5000; shake = 16'd1000;
      end
      1: begin
        flags = 16'h000B; x_org = 16'd1234; y_org = 16'hF830;
        turn = 16'd3000; tilt = 16'd2000; shake = 16'd500;
      end
      2: begin
        flags = 16'hFFFF; x_org = 16'h8000; y_org = 16'h7FFF;
        turn = 16'h0000; tilt = 16'h0000; shake = 16'h0000;
      end
      3: begin
        flags = 16'h0000; x_org = 16'h7FFF; y_org = 16'h8000;
        turn = 16'hFFFF; tilt = 16'hFFFF; shake = 16'h7FFF;
      end
      default: begin
        flags = 16'($urandom);
        x_org = 16'($urandom);
        y_org = 16'($urandom);
        turn  = {1'($urandom_range(1)), 15'($urandom_range(12000))};
        tilt  = {1'($urandom_range(1)), 15'($urandom_range(12000))};
        shake = {1'($urandom_range(1)), 15'($urandom_range(6000))};
      end
    endcase
    write_register(REG_ORIENTATION, flags);
    write_register(REG_X_ORIGIN, x_org);
    write_register(REG_Y_ORIGIN, y_org);
    write_register(REG_TURN_THR, turn);
    write_register(REG_TILT_THR, tilt);
    write_register(REG_SHAKE_THR, shake);
    n_settings++;
  endtask

  // Mostly runs of one class with random content, so that long presses and the
  // hibernate run come up; the rest is unshaped noise.
  task automatic run_random(int count);
    int       sent;
    int       run;
    int       consume_pct;
    int       pick;
    gesture_t target;
    sample_t  ax;
    sample_t  ay;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_sample(sample_t'($urandom), sample_t'($urandom), 1'($urandom_range(1)));
        sent++;
      end else begin
        case ($urandom_range(5))
          0: target = G_LEFT;
          1: target = G_RIGHT;
          2: target = G_UP;
          3: target = G_DOWN;
          4: target = G_SHAKE;
          default: target = G_UNKNOWN;
        endcase
        pick = $urandom_range(99);
        if (pick < 70) run = $urandom_range(4, 1);
        else if (pick < 92) run = $urandom_range(44, 38);
        else run = $urandom_range(66, 60);
        // The last run of a phase is cut so the phase ends on its item count.
        if (run > count - sent) run = count - sent;
        case ($urandom_range(2))
          0: consume_pct = 0;
          1: consume_pct = 30;
          default: consume_pct = 100;
        endcase
        repeat (run) begin
          shape_sample(target, ax, ay);
          send_sample(ax, ay, ($urandom_range(99) < consume_pct));
          sent++;
        end
      end
    end
  endtask

  initial begin
    pace_t pace;
    rst                 = 1'b1;
    sample_bus.valid    = 1'b0;
    sample_bus.raw_ax   = '0;
    sample_bus.raw_ay   = '0;
    sample_bus.consumed = 1'b0;
    result_bus.ready    = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_ORIENTATION;
    cfg_bus.data        = '0;
    model_cfg    = '{4'd0, 16'sd0, 16'sd0, 15'd4000, 15'd5000, 15'd1000};
    held_valid   = 1'b0;
    held_gesture = G_UNKNOWN;
    prev_class   = G_UNKNOWN;
    prev2_class  = G_UNKNOWN;
    run_len      = '0;
    n_errors = 0; n_samples = 0; n_results = 0; n_writes = 0; n_settings = 0;
    n_long_press = 0; n_hibernate = 0; cycles = 0;
    idle_pct = 0; stall_pct = 0;
    cfg_open = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    for (int i = 0; i < $size(directed_table); i++) begin
      if (directed_table[i].is_write)
        write_register(directed_table[i].index, directed_table[i].ax);
      else
        send_sample(directed_table[i].ax, directed_table[i].ay, directed_table[i].consumed,
                    directed_table[i].typed, directed_table[i].want);
    end

    // Random part: each phase gets its own setting and one of four idling patterns.
    for (int phase = 0; phase < PHASES; phase++) begin
      program_setting(phase);
      pace = pace_t'(phase % 4);
      case (pace)
        PACE_SENDER_GAPS:     begin idle_pct = 52; stall_pct <= 0;  end
        PACE_RECEIVER_STALLS: begin idle_pct = 0;  stall_pct <= 52; end
        PACE_BOTH:            begin idle_pct = 16; stall_pct <= 16; end
        default:              begin idle_pct = 0;  stall_pct <= 0;  end
      endcase
      run_random(PHASE_ITEMS);
    end

    sample_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    $display("Sent %0d samples and checked %0d results over %0d register settings (%0d writes).",
             n_samples, n_results, n_settings, n_writes);
    $display("Predicted latches: %0d long presses, %0d hibernate.", n_long_press, n_hibernate);
    if (n_errors == 0) begin
      $display("tilt_gesture_classifier_top_test: clean");
    end else begin
      $display("tilt_gesture_classifier_top_test: errors");
    end
    $finish;
  end

endmodule
